[sv/faq_pkg.sv]
`timescale 1ns / 1ps

package faq_pkg;

  localparam int unsigned TIME_W     = 48;
  localparam int unsigned DELTA_W    = 16;
  localparam int unsigned SUM_W      = 32;
  localparam int unsigned CFG_W      = 32;
  localparam int unsigned THRESH_W   = 31;
  localparam int unsigned CFG_ADDR_W = 4;

  localparam logic [CFG_W-1:0]    REARM_PAUSE_RESET = 32'd100000;
  localparam logic [CFG_W-1:0]    WINDOW_RESET      = 32'd200000;
  localparam logic [THRESH_W-1:0] THRESHOLD_RESET   = 31'd0;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_REARM_PAUSE = 2'd0,
    REG_WINDOW      = 2'd1,
    REG_THRESHOLD   = 2'd2,
    REG_NONE        = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_ARMED = 3'b001,
    PH_ACCUM = 3'b010,
    PH_WAIT  = 3'b100
  } phase_t;

  typedef struct packed {
    phase_t                    phase;
    logic signed [SUM_W-1:0]   motion_sum;
    logic        [TIME_W-1:0]  window_start;
    logic        [TIME_W-1:0]  last_event_time;
    logic                      seen_event;
  } state_t;

  typedef struct packed {
    logic [CFG_W-1:0]    rearm_pause_us;
    logic [CFG_W-1:0]    window_us;
    logic [THRESH_W-1:0] fire_threshold;
  } cfg_t;

  typedef struct packed {
    logic fired;
    logic direction;
    logic discarded;
  } result_t;

  localparam state_t STATE_CLEAR = '{
    phase:           PH_ARMED,
    motion_sum:      '0,
    window_start:    '0,
    last_event_time: '0,
    seen_event:      1'b0
  };

endpackage

[sv/faq_req_if.sv]
`timescale 1ns / 1ps

interface faq_req_if;
  logic                               valid;
  logic                               ready;
  logic                               req_type;
  logic signed [faq_pkg::DELTA_W-1:0] delta;
  logic        [faq_pkg::TIME_W-1:0]  timestamp_us;

  modport source (output valid, req_type, delta, timestamp_us, input ready);
  modport sink   (input valid, req_type, delta, timestamp_us, output ready);
endinterface

[sv/faq_res_if.sv]
`timescale 1ns / 1ps

interface faq_res_if;
  logic valid;
  logic ready;
  logic fired;
  logic direction;
  logic discarded;

  modport source (output valid, fired, direction, discarded, input ready);
  modport sink   (input valid, fired, direction, discarded, output ready);
endinterface

[sv/flick_accumulation_qualifier.sv]
`timescale 1ns / 1ps

// Channel | Dir | Fields                              | Handshake
// req     | in  | req_type, delta[15:0], timestamp_us | valid/ready
// res     | out | fired, direction, discarded         | valid/ready
// apb     | in  | paddr[3:0], pwdata[31:0] -> prdata  | psel/penable, pready tied high
//
// One word per cycle while req.ready is high: each word updates the state in the cycle
// it is taken, and its result sits in the output register in the next cycle.
// req.ready stays high while the output register is empty or being drained,
// so a stall on res holds at most one result and then back-pressures req.
// rst is synchronous; it clears the state and the configuration registers to their
// defaults and empties the output register.
module flick_accumulation_qualifier (
  input  logic                               clk,
  input  logic                               rst,
  faq_req_if.sink                            req,
  faq_res_if.source                          res,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [faq_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [faq_pkg::CFG_W-1:0]          pwdata,
  output logic [faq_pkg::CFG_W-1:0]          prdata,
  output logic                               pready
);

  faq_pkg::cfg_t     cfg;
  faq_pkg::state_t   state;
  faq_pkg::state_t   state_next;
  faq_pkg::result_t  step_res;
  faq_pkg::result_t  out_word;
  faq_pkg::reg_idx_t reg_sel;
  logic              out_valid;
  logic              accept;
  logic              cfg_write;

  assign pready    = 1'b1;
  assign reg_sel   = faq_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rearm_pause_us <= faq_pkg::REARM_PAUSE_RESET;
      cfg.window_us      <= faq_pkg::WINDOW_RESET;
      cfg.fire_threshold <= faq_pkg::THRESHOLD_RESET;
    end else if (cfg_write) begin
      unique case (reg_sel)
        faq_pkg::REG_REARM_PAUSE: cfg.rearm_pause_us <= pwdata;
        faq_pkg::REG_WINDOW:      cfg.window_us      <= pwdata;
        faq_pkg::REG_THRESHOLD:   cfg.fire_threshold <= pwdata[faq_pkg::THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      faq_pkg::REG_REARM_PAUSE: prdata = cfg.rearm_pause_us;
      faq_pkg::REG_WINDOW:      prdata = cfg.window_us;
      faq_pkg::REG_THRESHOLD:   prdata = {1'b0, cfg.fire_threshold};
      default:                  prdata = '0;
    endcase
  end

  assign req.ready = !out_valid || res.ready;
  assign accept    = req.valid && req.ready;

  faq_step u_step (
    .cur      (state),
    .cfg      (cfg),
    .req_type (req.req_type),
    .delta    (req.delta),
    .now      (req.timestamp_us),
    .nxt      (state_next),
    .res      (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= faq_pkg::STATE_CLEAR;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // output register: load on accept, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_word <= step_res;
    end
  end

  assign res.valid     = out_valid;
  assign res.fired     = out_word.fired;
  assign res.direction = out_word.direction;
  assign res.discarded = out_word.discarded;

endmodule

[sv/faq_step.sv]
`timescale 1ns / 1ps

// Next state and result for one word, given the current state.
module faq_step (
  input  faq_pkg::state_t                    cur,
  input  faq_pkg::cfg_t                      cfg,
  input  logic                               req_type,
  input  logic signed [faq_pkg::DELTA_W-1:0] delta,
  input  logic        [faq_pkg::TIME_W-1:0]  now,
  output faq_pkg::state_t                    nxt,
  output faq_pkg::result_t                   res
);

  logic [faq_pkg::TIME_W-1:0]         gap;
  logic [faq_pkg::TIME_W-1:0]         age;
  logic                               paused;
  logic                               expired;
  logic                               restart;
  logic signed [faq_pkg::SUM_W-1:0]   base_sum;
  logic signed [faq_pkg::SUM_W:0]     sum_wide;
  logic signed [faq_pkg::SUM_W-1:0]   sum_sat;
  logic        [faq_pkg::SUM_W-1:0]   mag;
  logic                               fire;

  assign gap = now - cur.last_event_time;
  assign age = now - cur.window_start;

  // a backwards step in time is no pause and no expiry
  assign paused  = !cur.seen_event ||
                   ((now >= cur.last_event_time) &&
                    (gap >= {{(faq_pkg::TIME_W-faq_pkg::CFG_W){1'b0}}, cfg.rearm_pause_us}));
  assign expired = (now >= cur.window_start) &&
                   (age > {{(faq_pkg::TIME_W-faq_pkg::CFG_W){1'b0}}, cfg.window_us});

  // a word after waiting with a pause restarts, as armed always does
  assign restart  = (cur.phase != faq_pkg::PH_ACCUM) || paused || expired;
  assign base_sum = restart ? '0 : cur.motion_sum;
  assign sum_wide = {base_sum[faq_pkg::SUM_W-1], base_sum} +
                    {{(faq_pkg::SUM_W+1-faq_pkg::DELTA_W){delta[faq_pkg::DELTA_W-1]}}, delta};

  always_comb begin
    if (sum_wide[faq_pkg::SUM_W] != sum_wide[faq_pkg::SUM_W-1]) begin
      sum_sat = sum_wide[faq_pkg::SUM_W] ? faq_pkg::SUM_MIN : faq_pkg::SUM_MAX;
    end else begin
      sum_sat = sum_wide[faq_pkg::SUM_W-1:0];
    end
  end

  assign mag  = sum_sat[faq_pkg::SUM_W-1] ? (~sum_sat + 1'b1) : sum_sat;
  assign fire = (cfg.fire_threshold != '0) &&
                (mag >= {{(faq_pkg::SUM_W-faq_pkg::THRESH_W){1'b0}}, cfg.fire_threshold});

  always_comb begin
    nxt = cur;
    res = '0;
    priority if (req_type) begin
      nxt = faq_pkg::STATE_CLEAR;
    end else if ((cur.phase == faq_pkg::PH_WAIT) && !paused) begin
      nxt.last_event_time = now;
      nxt.seen_event      = 1'b1;
      res.discarded       = 1'b1;
    end else begin
      nxt.last_event_time = now;
      nxt.seen_event      = 1'b1;
      if (fire) begin
        nxt.phase        = faq_pkg::PH_WAIT;
        nxt.motion_sum   = '0;
        nxt.window_start = '0;
        res.fired        = 1'b1;
        res.direction    = !sum_sat[faq_pkg::SUM_W-1];
      end else begin
        nxt.phase        = faq_pkg::PH_ACCUM;
        nxt.motion_sum   = sum_sat;
        nxt.window_start = restart ? now : cur.window_start;
      end
    end
  end

endmodule

[sv/faq_checker.sv]
`timescale 1ns / 1ps

module faq_checker (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic req_type,
  input logic res_valid,
  input logic res_ready,
  input logic fired,
  input logic direction,
  input logic discarded
);

  logic req_acc;
  assign req_acc = req_valid && req_ready;

  // every word taken shows its result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    req_acc |=> res_valid)
    else $error("no result after accepted word");

  // a re-arm command answers with an all-zero result
  a_rearm_zero: assert property (@(posedge clk) disable iff (rst)
    (req_acc && req_type) |=> (!fired && !direction && !discarded))
    else $error("re-arm result not zero");

  a_fire_xor_discard: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(fired && discarded))
    else $error("fired and discarded together");

  a_direction_idle: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !fired) |-> !direction)
    else $error("direction set without fire");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result valid straight after reset");

endmodule

bind flick_accumulation_qualifier faq_checker u_faq_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .req_type  (req.req_type),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .fired     (res.fired),
  .direction (res.direction),
  .discarded (res.discarded)
);
